// File: sv/swbf_pkg.sv
// Shared types, register codes and constants of the SPH wall boundary force block.
package swbf_pkg;

  // Configuration register indexes, in port order.
  typedef enum logic [2:0] {
    REG_WALL_X_LOW  = 3'd0,
    REG_WALL_X_HIGH = 3'd1,
    REG_WALL_Y_LOW  = 3'd2,
    REG_WALL_Y_HIGH = 3'd3,
    REG_WALL_Z_LOW  = 3'd4,
    REG_CONTACT_RNG = 3'd5,
    REG_STIFFNESS   = 3'd6,
    REG_DAMPING     = 3'd7
  } cfg_reg_e;

  // Bit positions of the walls in the contact mask.
  localparam int unsigned WALL_ZL = 0;
  localparam int unsigned WALL_YL = 1;
  localparam int unsigned WALL_YH = 2;
  localparam int unsigned WALL_XL = 3;
  localparam int unsigned WALL_XH = 4;
  localparam int unsigned NUM_WALLS = 5;

  // Penetration depth must exceed this (Q16.16 LSBs) for contact.
  localparam logic signed [34:0] CONTACT_EPSILON = 35'sd1;

  // Reset values of the wall coordinates (1.0 in Q16.16 for the high walls).
  localparam logic signed [31:0] WALL_LOW_RESET  = 32'sd0;
  localparam logic signed [31:0] WALL_HIGH_RESET = 32'sd65536;

  // Input word: one particle.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] new_force_x;
    logic signed [31:0] new_force_y;
    logic signed [31:0] new_force_z;
    logic [4:0]         contact_mask;
    logic               saturated;
  } out_word_t;

  // Current configuration register contents.
  typedef struct packed {
    logic signed [31:0] wall_x_low;
    logic signed [31:0] wall_x_high;
    logic signed [31:0] wall_y_low;
    logic signed [31:0] wall_y_high;
    logic signed [31:0] wall_z_low;
    logic [30:0]        contact_range;
    logic [30:0]        wall_stiffness;
    logic [30:0]        wall_damping;
  } cfg_t;

  // Products stage: stiffness products, damping products, contact and friction flags.
  typedef struct packed {
    logic [63:0]        prod_zl;
    logic [63:0]        prod_yl;
    logic [63:0]        prod_yh;
    logic [63:0]        prod_xl;
    logic [63:0]        prod_xh;
    logic signed [63:0] dv_x;
    logic signed [63:0] dv_y;
    logic signed [63:0] dv_z;
    logic [4:0]         contact;
    logic               fric_x;
    logic               fric_y;
    logic               fric_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } prod_t;

  // Coefficient stage: per-wall repulsion and per-axis friction totals.
  typedef struct packed {
    logic signed [49:0] c_zl;
    logic signed [49:0] c_yl;
    logic signed [49:0] c_yh;
    logic signed [49:0] c_xl;
    logic signed [49:0] c_xh;
    logic signed [34:0] fr_x;
    logic signed [34:0] fr_y;
    logic signed [34:0] fr_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [4:0]         contact;
  } coeff_t;

endpackage

// File: sv/swbf_cfg_regs.sv
// Configuration register file of the SPH wall boundary force block.
module swbf_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [2:0]         wr_index_i,
  input  logic [31:0]        wr_data_i,
  output swbf_pkg::cfg_t     cfg_o
);

  swbf_pkg::cfg_t cfg_q;
  swbf_pkg::cfg_t cfg_d;

  // Write decode; the unsigned registers keep only their low 31 bits.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (swbf_pkg::cfg_reg_e'(wr_index_i))
        swbf_pkg::REG_WALL_X_LOW:  cfg_d.wall_x_low     = wr_data_i;
        swbf_pkg::REG_WALL_X_HIGH: cfg_d.wall_x_high    = wr_data_i;
        swbf_pkg::REG_WALL_Y_LOW:  cfg_d.wall_y_low     = wr_data_i;
        swbf_pkg::REG_WALL_Y_HIGH: cfg_d.wall_y_high    = wr_data_i;
        swbf_pkg::REG_WALL_Z_LOW:  cfg_d.wall_z_low     = wr_data_i;
        swbf_pkg::REG_CONTACT_RNG: cfg_d.contact_range  = wr_data_i[30:0];
        swbf_pkg::REG_STIFFNESS:   cfg_d.wall_stiffness = wr_data_i[30:0];
        swbf_pkg::REG_DAMPING:     cfg_d.wall_damping   = wr_data_i[30:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  // Register state with reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wall_x_low     <= swbf_pkg::WALL_LOW_RESET;
      cfg_q.wall_x_high    <= swbf_pkg::WALL_HIGH_RESET;
      cfg_q.wall_y_low     <= swbf_pkg::WALL_LOW_RESET;
      cfg_q.wall_y_high    <= swbf_pkg::WALL_HIGH_RESET;
      cfg_q.wall_z_low     <= swbf_pkg::WALL_LOW_RESET;
      cfg_q.contact_range  <= '0;
      cfg_q.wall_stiffness <= '0;
      cfg_q.wall_damping   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/swbf_contact.sv
// Depth, contact test and multiplier stage of the SPH wall boundary force block.
module swbf_contact (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  swbf_pkg::in_word_t word_i,
  input  swbf_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output swbf_pkg::prod_t    stage_o
);

  logic                     valid_q;
  swbf_pkg::prod_t          stage_q;
  swbf_pkg::prod_t          stage_d;
  logic signed [34:0]       depth [swbf_pkg::NUM_WALLS];
  logic signed [32:0]       sum_yz, sum_zx, sum_xy;

  // Depth of one wall: contact range minus the 33-bit distance to it.
  function automatic logic signed [34:0] depth_of(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [30:0] range);
    logic signed [32:0] gap;
    gap = $signed({a[31], a}) - $signed({b[31], b});
    return $signed({4'b0000, range}) - $signed({{2{gap[32]}}, gap});
  endfunction

  // Stiffness times a non-negative 33-bit depth, exact in 64 bits.
  function automatic logic [63:0] mul_depth(input logic [30:0] k, input logic [32:0] d);
    return {33'd0, k} * {31'd0, d};
  endfunction

  // Damping times a signed velocity component, exact in 64 bits.
  function automatic logic signed [63:0] mul_vel(input logic [30:0] k,
                                                 input logic signed [31:0] v);
    return $signed({33'd0, k}) * $signed({{32{v[31]}}, v});
  endfunction

  // Distances are position minus wall for low walls, wall minus position for high.
  always_comb begin
    depth[swbf_pkg::WALL_ZL] = depth_of(word_i.pos_z, cfg_i.wall_z_low, cfg_i.contact_range);
    depth[swbf_pkg::WALL_YL] = depth_of(word_i.pos_y, cfg_i.wall_y_low, cfg_i.contact_range);
    depth[swbf_pkg::WALL_YH] = depth_of(cfg_i.wall_y_high, word_i.pos_y, cfg_i.contact_range);
    depth[swbf_pkg::WALL_XL] = depth_of(word_i.pos_x, cfg_i.wall_x_low, cfg_i.contact_range);
    depth[swbf_pkg::WALL_XH] = depth_of(cfg_i.wall_x_high, word_i.pos_x, cfg_i.contact_range);
  end

  // Sums of the two tangential velocity components for each wall axis.
  assign sum_yz = $signed({word_i.vel_y[31], word_i.vel_y})
                + $signed({word_i.vel_z[31], word_i.vel_z});
  assign sum_zx = $signed({word_i.vel_z[31], word_i.vel_z})
                + $signed({word_i.vel_x[31], word_i.vel_x});
  assign sum_xy = $signed({word_i.vel_x[31], word_i.vel_x})
                + $signed({word_i.vel_y[31], word_i.vel_y});

  // Contact flags, friction flags and products. A depth in contact is positive and below 2^33.
  always_comb begin
    for (int w = 0; w < swbf_pkg::NUM_WALLS; w++) begin
      stage_d.contact[w] = depth[w] > swbf_pkg::CONTACT_EPSILON;
    end
    stage_d.prod_zl = mul_depth(cfg_i.wall_stiffness, depth[swbf_pkg::WALL_ZL][32:0]);
    stage_d.prod_yl = mul_depth(cfg_i.wall_stiffness, depth[swbf_pkg::WALL_YL][32:0]);
    stage_d.prod_yh = mul_depth(cfg_i.wall_stiffness, depth[swbf_pkg::WALL_YH][32:0]);
    stage_d.prod_xl = mul_depth(cfg_i.wall_stiffness, depth[swbf_pkg::WALL_XL][32:0]);
    stage_d.prod_xh = mul_depth(cfg_i.wall_stiffness, depth[swbf_pkg::WALL_XH][32:0]);
    stage_d.dv_x    = mul_vel(cfg_i.wall_damping, word_i.vel_x);
    stage_d.dv_y    = mul_vel(cfg_i.wall_damping, word_i.vel_y);
    stage_d.dv_z    = mul_vel(cfg_i.wall_damping, word_i.vel_z);
    stage_d.fric_x  = sum_yz > 33'sd0;
    stage_d.fric_y  = sum_zx > 33'sd0;
    stage_d.fric_z  = sum_xy > 33'sd0;
    stage_d.vel_x   = word_i.vel_x;
    stage_d.vel_y   = word_i.vel_y;
    stage_d.vel_z   = word_i.vel_z;
    stage_d.force_x = word_i.force_x;
    stage_d.force_y = word_i.force_y;
    stage_d.force_z = word_i.force_z;
  end

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// File: sv/swbf_coeff.sv
// Repulsion coefficient and friction stage of the SPH wall boundary force block.
module swbf_coeff (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  swbf_pkg::prod_t    stage_i,
  output logic               valid_o,
  output swbf_pkg::coeff_t   stage_o
);

  logic                     valid_q;
  swbf_pkg::coeff_t         stage_q;
  swbf_pkg::coeff_t         stage_d;
  logic signed [34:0]       vx, vy, vz;
  logic                     zl, yl, yh, xl, xh;

  // Coefficient floor((prod - dnv) / 2^16), or zero without contact.
  // For a low wall dnv is +damping*v, for a high wall it is -damping*v.
  function automatic logic signed [49:0] coeff_of(input logic [63:0] prod,
                                                  input logic signed [63:0] dv,
                                                  input logic high_wall,
                                                  input logic hit);
    logic signed [65:0] dv_ext;
    logic signed [65:0] num;
    dv_ext = $signed({{2{dv[63]}}, dv});
    if (high_wall) begin
      num = $signed({2'b00, prod}) + dv_ext;
    end else begin
      num = $signed({2'b00, prod}) - dv_ext;
    end
    return hit ? $signed(num[65:16]) : 50'sd0;
  endfunction

  assign zl = stage_i.contact[swbf_pkg::WALL_ZL];
  assign yl = stage_i.contact[swbf_pkg::WALL_YL];
  assign yh = stage_i.contact[swbf_pkg::WALL_YH];
  assign xl = stage_i.contact[swbf_pkg::WALL_XL];
  assign xh = stage_i.contact[swbf_pkg::WALL_XH];

  assign vx = $signed({{3{stage_i.vel_x[31]}}, stage_i.vel_x});
  assign vy = $signed({{3{stage_i.vel_y[31]}}, stage_i.vel_y});
  assign vz = $signed({{3{stage_i.vel_z[31]}}, stage_i.vel_z});

  // Each wall in contact with its friction condition met removes the
  // tangential velocity once along both tangent axes.
  always_comb begin
    stage_d.c_zl = coeff_of(stage_i.prod_zl, stage_i.dv_z, 1'b0, zl);
    stage_d.c_yl = coeff_of(stage_i.prod_yl, stage_i.dv_y, 1'b0, yl);
    stage_d.c_yh = coeff_of(stage_i.prod_yh, stage_i.dv_y, 1'b1, yh);
    stage_d.c_xl = coeff_of(stage_i.prod_xl, stage_i.dv_x, 1'b0, xl);
    stage_d.c_xh = coeff_of(stage_i.prod_xh, stage_i.dv_x, 1'b1, xh);
    stage_d.fr_x = ((zl && stage_i.fric_z) ? vx : 35'sd0)
                 + ((yl && stage_i.fric_y) ? vx : 35'sd0)
                 + ((yh && stage_i.fric_y) ? vx : 35'sd0);
    stage_d.fr_y = ((zl && stage_i.fric_z) ? vy : 35'sd0)
                 + ((xl && stage_i.fric_x) ? vy : 35'sd0)
                 + ((xh && stage_i.fric_x) ? vy : 35'sd0);
    stage_d.fr_z = ((yl && stage_i.fric_y) ? vz : 35'sd0)
                 + ((yh && stage_i.fric_y) ? vz : 35'sd0)
                 + ((xl && stage_i.fric_x) ? vz : 35'sd0)
                 + ((xh && stage_i.fric_x) ? vz : 35'sd0);
    stage_d.force_x = stage_i.force_x;
    stage_d.force_y = stage_i.force_y;
    stage_d.force_z = stage_i.force_z;
    stage_d.contact = stage_i.contact;
  end

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// File: sv/swbf_accum.sv
// Force summation and saturation stage of the SPH wall boundary force block.
module swbf_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  swbf_pkg::coeff_t    stage_i,
  output logic                valid_o,
  output swbf_pkg::out_word_t res_o
);

  logic                     valid_q;
  swbf_pkg::out_word_t      res_q;
  swbf_pkg::out_word_t      res_d;
  logic signed [51:0]       acc_x, acc_y, acc_z;
  logic [32:0]              sat_x, sat_y, sat_z;

  // Sign extensions to the accumulator width.
  function automatic logic signed [51:0] ext32(input logic signed [31:0] v);
    return $signed({{20{v[31]}}, v});
  endfunction

  function automatic logic signed [51:0] ext35(input logic signed [34:0] v);
    return $signed({{17{v[34]}}, v});
  endfunction

  function automatic logic signed [51:0] ext50(input logic signed [49:0] v);
    return $signed({{2{v[49]}}, v});
  endfunction

  // Clamp to signed 32 bits; the top bit of the result flags a clamp.
  function automatic logic [32:0] clamp32(input logic signed [51:0] v);
    logic all_ones;
    logic all_zero;
    all_ones = &v[51:31];
    all_zero = ~|v[51:31];
    if (all_ones || all_zero) begin
      return {1'b0, v[31:0]};
    end else if (v[51]) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b1, 32'h7FFF_FFFF};
    end
  endfunction

  // Input force plus signed wall repulsions minus friction.
  assign acc_x = ext32(stage_i.force_x) + ext50(stage_i.c_xl) - ext50(stage_i.c_xh)
               - ext35(stage_i.fr_x);
  assign acc_y = ext32(stage_i.force_y) + ext50(stage_i.c_yl) - ext50(stage_i.c_yh)
               - ext35(stage_i.fr_y);
  assign acc_z = ext32(stage_i.force_z) + ext50(stage_i.c_zl) - ext35(stage_i.fr_z);

  assign sat_x = clamp32(acc_x);
  assign sat_y = clamp32(acc_y);
  assign sat_z = clamp32(acc_z);

  // Result word assembly.
  always_comb begin
    res_d.new_force_x  = sat_x[31:0];
    res_d.new_force_y  = sat_y[31:0];
    res_d.new_force_z  = sat_z[31:0];
    res_d.contact_mask = stage_i.contact;
    res_d.saturated    = sat_x[32] | sat_y[32] | sat_z[32];
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: sv/sph_wall_boundary_force.sv
// Top level of the SPH wall boundary force block.
// The block takes one particle word per clock cycle: busy_o stays low, so a
// word is accepted at every edge where start_i is high. Each word yields one
// result word on res_o, marked by done_o for a single cycle; the receiver
// cannot stall it. The word passes in order through the input register, the
// multiplier stage (stiffness times depth per wall, damping times velocity per
// axis), the coefficient stage and the summing and saturation stage.
// Configuration writes are always ready and take effect at once; write them
// only while no word is in flight.
module sph_wall_boundary_force (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  swbf_pkg::in_word_t  in_i,
  output logic                done_o,
  output swbf_pkg::out_word_t res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic                in_vld_q;
  swbf_pkg::in_word_t  in_q;
  swbf_pkg::cfg_t      cfg;
  logic                prod_vld;
  swbf_pkg::prod_t     prod;
  logic                coeff_vld;
  swbf_pkg::coeff_t    coeff;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= in_i;
    end
  end

  swbf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  swbf_contact u_contact (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .word_i  (in_q),
    .cfg_i   (cfg),
    .valid_o (prod_vld),
    .stage_o (prod)
  );

  swbf_coeff u_coeff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_vld),
    .stage_i (prod),
    .valid_o (coeff_vld),
    .stage_o (coeff)
  );

  swbf_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coeff_vld),
    .stage_i (coeff),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule

// File: sv/swbf_checker.sv
// Port-level checker of the SPH wall boundary force block and its bind.
module swbf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input swbf_pkg::in_word_t  in_i,
  input logic                done_o,
  input swbf_pkg::out_word_t res_o
);

  // Every accepted word yields a result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("accepted word produced no result after four cycles");

  // No result appears without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result word without a matching accepted word");

  // Without wall contact the input force passes through unchanged.
  a_no_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.contact_mask == 5'd0 |->
      res_o.new_force_x == $past(in_i.force_x, 4) &&
      res_o.new_force_y == $past(in_i.force_y, 4) &&
      res_o.new_force_z == $past(in_i.force_z, 4) && !res_o.saturated)
    else $error("force changed although no wall is in contact");

  // A saturated result has at least one component at a 32-bit limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.saturated |->
      res_o.new_force_x == 32'sh7FFF_FFFF || res_o.new_force_x == 32'sh8000_0000 ||
      res_o.new_force_y == 32'sh7FFF_FFFF || res_o.new_force_y == 32'sh8000_0000 ||
      res_o.new_force_z == 32'sh7FFF_FFFF || res_o.new_force_z == 32'sh8000_0000)
    else $error("saturation flagged but no component is clamped");

endmodule

bind sph_wall_boundary_force swbf_checker u_swbf_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the SPH wall boundary force block.
`timescale 1ns / 1ps

module tb_top;

  localparam int          Q16         = 65536;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // Axis of each wall in contact mask order: z low, y low, y high, x low, x high.
  localparam int          AXIS_OF [swbf_pkg::NUM_WALLS] = '{2, 1, 1, 0, 0};

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  swbf_pkg::in_word_t  in_i;
  logic      done_o;
  swbf_pkg::out_word_t res_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Register contents as the block should hold them.
  swbf_pkg::cfg_t      regs;
  // Predicted result words, oldest first.
  swbf_pkg::out_word_t pending_forces [$];
  swbf_pkg::out_word_t head;
  bit        gaps_on;
  int unsigned n_sent, n_checked, n_contact, n_clamped, n_settings, n_errors, n_cycles;

  sph_wall_boundary_force i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding",
               $time, n_cycles, pending_forces.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [95:0] wide(input logic signed [31:0] v);
    return $signed({{64{v[31]}}, v});
  endfunction

  function automatic logic signed [95:0] wide_u(input logic [30:0] v);
    return $signed({65'b0, v});
  endfunction

  // Wall forces for one particle under the current register contents.
  function automatic swbf_pkg::out_word_t wall_force_of(input swbf_pkg::in_word_t p);
    logic signed [95:0] pos [3];
    logic signed [95:0] vel [3];
    logic signed [95:0] acc [3];
    logic signed [95:0] wall, span, depth, nv, coeff;
    int axis, a1, a2;
    bit is_high;
    swbf_pkg::out_word_t r;
    r = '0;
    pos[0] = wide(p.pos_x);   pos[1] = wide(p.pos_y);   pos[2] = wide(p.pos_z);
    vel[0] = wide(p.vel_x);   vel[1] = wide(p.vel_y);   vel[2] = wide(p.vel_z);
    acc[0] = wide(p.force_x); acc[1] = wide(p.force_y); acc[2] = wide(p.force_z);
    for (int w = 0; w < swbf_pkg::NUM_WALLS; w++) begin
      case (w)
        swbf_pkg::WALL_ZL: wall = wide(regs.wall_z_low);
        swbf_pkg::WALL_YL: wall = wide(regs.wall_y_low);
        swbf_pkg::WALL_YH: wall = wide(regs.wall_y_high);
        swbf_pkg::WALL_XL: wall = wide(regs.wall_x_low);
        default:           wall = wide(regs.wall_x_high);
      endcase
      axis    = AXIS_OF[w];
      is_high = (w == swbf_pkg::WALL_YH) || (w == swbf_pkg::WALL_XH);
      span    = is_high ? wall - pos[axis] : pos[axis] - wall;
      depth   = wide_u(regs.contact_range) - span;
      if (depth > swbf_pkg::CONTACT_EPSILON) begin
        // Normal velocity is taken along the inward normal of the wall.
        nv    = is_high ? -vel[axis] : vel[axis];
        coeff = (wide_u(regs.wall_stiffness) * depth - wide_u(regs.wall_damping) * nv) >>> 16;
        acc[axis] = is_high ? acc[axis] - coeff : acc[axis] + coeff;
        // Friction opposes the tangential velocity only when its sum is positive.
        a1 = (axis + 1) % 3;
        a2 = (axis + 2) % 3;
        if (vel[a1] + vel[a2] > 0) begin
          acc[a1] = acc[a1] - vel[a1];
          acc[a2] = acc[a2] - vel[a2];
        end
        r.contact_mask[w] = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (acc[i] > 96'sd2147483647) begin
        acc[i] = 96'sd2147483647;
        r.saturated = 1'b1;
      end else if (acc[i] < -96'sd2147483648) begin
        acc[i] = -96'sd2147483648;
        r.saturated = 1'b1;
      end
    end
    r.new_force_x = acc[0][31:0];
    r.new_force_y = acc[1][31:0];
    r.new_force_z = acc[2][31:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Each result word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_forces.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual %h",
                 $time, res_o);
        n_errors++;
      end else begin
        head = pending_forces.pop_front();
        check_field("new_force_x", head.new_force_x, res_o.new_force_x);
        check_field("new_force_y", head.new_force_y, res_o.new_force_y);
        check_field("new_force_z", head.new_force_z, res_o.new_force_z);
        check_field("contact_mask", 32'(head.contact_mask), 32'(res_o.contact_mask));
        check_field("saturated", 32'(head.saturated), 32'(res_o.saturated));
        n_checked++;
        if (head.contact_mask != '0) n_contact++;
        if (head.saturated) n_clamped++;
      end
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Uniform value within spread of center, clamped to 32 bits.
  function automatic logic signed [31:0] near(input longint center, input longint spread);
    longint off;
    off = $signed({$urandom, $urandom}) % (spread + 1);
    return clamp32(center + off);
  endfunction

  // Velocity or force component: mostly modest, sometimes wild or near the limits.
  function automatic logic signed [31:0] rand_q(input longint modest);
    case ($urandom_range(10))
      0, 1, 2, 3, 4, 5: return near(0, modest);
      6, 7:             return $urandom;
      8:                return near(64'sd2147483647, 4096);
      9:                return near(-64'sd2147483648, 4096);
      default:          return '0;
    endcase
  endfunction

  // Position along one axis, mostly close to one of its walls.
  function automatic logic signed [31:0] rand_axis(input longint lo_wall, input longint hi_wall,
                                                   input bit has_high);
    longint spread;
    spread = longint'(regs.contact_range) + 8;
    case ($urandom_range(9))
      0, 1:          return $urandom;
      2, 3, 4, 5:    return near(lo_wall, spread);
      default:       return has_high ? near(hi_wall, spread) : near(lo_wall, spread);
    endcase
  endfunction

  function automatic swbf_pkg::in_word_t rand_particle();
    swbf_pkg::in_word_t w;
    if ($urandom_range(6) == 0) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      return w;
    end
    w.pos_x   = rand_axis(regs.wall_x_low, regs.wall_x_high, 1'b1);
    w.pos_y   = rand_axis(regs.wall_y_low, regs.wall_y_high, 1'b1);
    w.pos_z   = rand_axis(regs.wall_z_low, 0, 1'b0);
    w.vel_x   = rand_q(1 << 18);
    w.vel_y   = rand_q(1 << 18);
    w.vel_z   = rand_q(1 << 18);
    w.force_x = rand_q(1 << 22);
    w.force_y = rand_q(1 << 22);
    w.force_z = rand_q(1 << 22);
    return w;
  endfunction

  function automatic logic [30:0] rand_gain(input int unsigned typical);
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(0, typical));
    endcase
  endfunction

  // A random box of walls with random contact parameters.
  function automatic swbf_pkg::cfg_t rand_regs();
    swbf_pkg::cfg_t c;
    c.wall_x_low  = near(0, 1 << 24);
    c.wall_x_high = clamp32(longint'(c.wall_x_low) + longint'($urandom_range(0, 1 << 25)));
    c.wall_y_low  = near(0, 1 << 24);
    c.wall_y_high = clamp32(longint'(c.wall_y_low) + longint'($urandom_range(0, 1 << 25)));
    c.wall_z_low  = near(0, 1 << 24);
    if ($urandom_range(4) == 0) begin
      c.wall_x_low  = $urandom;
      c.wall_x_high = $urandom;
      c.wall_y_low  = $urandom;
      c.wall_y_high = $urandom;
      c.wall_z_low  = $urandom;
    end
    c.contact_range  = rand_gain(1 << 20);
    c.wall_stiffness = rand_gain(1 << 24);
    c.wall_damping   = rand_gain(1 << 20);
    return c;
  endfunction

  function automatic swbf_pkg::in_word_t particle(input int px, input int py, input int pz,
                                                  input int vx, input int vy, input int vz,
                                                  input int fx, input int fy, input int fz);
    swbf_pkg::in_word_t w;
    w = {px, py, pz, vx, vy, vz, fx, fy, fz};
    return w;
  endfunction

  // Lower start and hold off until every predicted word has come back.
  task automatic wait_drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_forces.size() != 0);
  endtask

  // Send one particle word; called and returning at a falling edge.
  task automatic send_particle(input swbf_pkg::in_word_t w);
    if (gaps_on && $urandom_range(99) < 30) begin
      start_i <= 1'b0;
      in_i    <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_forces.push_back(wall_force_of(w));
    n_sent++;
    @(negedge clk_i);
  endtask

  // Write all eight registers while the block is idle.
  task automatic program_regs(input swbf_pkg::cfg_t c);
    swbf_pkg::cfg_reg_e idx;
    logic [31:0]        data;
    logic               top_bit;
    wait_drain();
    for (int i = 0; i <= int'(swbf_pkg::REG_DAMPING); i++) begin
      idx     = swbf_pkg::cfg_reg_e'(i);
      top_bit = 1'($urandom_range(1));
      // The unsigned registers drop bit 31, so it carries noise.
      case (idx)
        swbf_pkg::REG_WALL_X_LOW:  data = c.wall_x_low;
        swbf_pkg::REG_WALL_X_HIGH: data = c.wall_x_high;
        swbf_pkg::REG_WALL_Y_LOW:  data = c.wall_y_low;
        swbf_pkg::REG_WALL_Y_HIGH: data = c.wall_y_high;
        swbf_pkg::REG_WALL_Z_LOW:  data = c.wall_z_low;
        swbf_pkg::REG_CONTACT_RNG: data = {top_bit, c.contact_range};
        swbf_pkg::REG_STIFFNESS:   data = {top_bit, c.wall_stiffness};
        default:                   data = {top_bit, c.wall_damping};
      endcase
      if (gaps_on && $urandom_range(99) < 30) begin
        cfg_valid_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    regs = c;
    n_settings++;
  endtask

  task automatic run_particles(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(249) == 0) wait_drain();
      send_particle(rand_particle());
    end
  endtask

  // Reset contents: unit box, no contact range, no stiffness, no damping.
  task automatic test_reset_defaults();
    send_particle(particle(Q16 / 2, Q16 / 2, Q16 / 2, 100, -200, 300, 7, 8, 9));
    send_particle(particle(-3, Q16 / 2, Q16 / 2, 10, 20, 30, 0, 0, 0));
    send_particle(particle(Q16 / 2, Q16 + 5, -7, -40, 90, 11, 1, 1, 1));
    // Depth of one LSB is no contact, two LSBs is.
    send_particle(particle(-1, Q16 / 2, Q16 / 2, 0, 5, 5, 0, 0, 0));
    send_particle(particle(-2, Q16 / 2, Q16 / 2, 0, 5, 5, 0, 0, 0));
  endtask

  // Hand-picked particles in a ten-unit box with a one-unit contact range.
  task automatic test_directed();
    swbf_pkg::cfg_t c;
    c.wall_x_low     = 0;
    c.wall_x_high    = 10 * Q16;
    c.wall_y_low     = 0;
    c.wall_y_high    = 10 * Q16;
    c.wall_z_low     = 0;
    c.contact_range  = 31'(Q16);
    c.wall_stiffness = 31'(2 * Q16);
    c.wall_damping   = 31'(Q16 / 2);
    program_regs(c);
    send_particle(particle(5 * Q16, 5 * Q16, 5 * Q16, 0, 0, 0, 1, 2, 3));
    send_particle({9{32'h7FFF_FFFF}});
    send_particle({9{32'h8000_0000}});
    send_particle('0);
    // Depth at epsilon and just above it on the floor.
    send_particle(particle(5 * Q16, 5 * Q16, Q16 - 1, 0, 0, 0, 0, 0, 0));
    send_particle(particle(5 * Q16, 5 * Q16, Q16 - 2, 0, 0, 0, 0, 0, 0));
    // Tangential sum of zero gives no friction, one LSB more gives friction.
    send_particle(particle(5 * Q16, 5 * Q16, 0, 5, -5, 0, 0, 0, 0));
    send_particle(particle(5 * Q16, 5 * Q16, 0, 5, -4, 0, 0, 0, 0));
    // Damping outweighs the spring: negative coefficient with a remainder.
    send_particle(particle(5 * Q16, 5 * Q16, Q16 / 2, 0, 0, 12345 * 29, 0, 0, 0));
    // Clamping at the top and at the bottom.
    send_particle(particle(5 * Q16, 5 * Q16, 0, 0, 0, -Q16, 0, 0, 32'h7FFF_FFF0));
    send_particle(particle(10 * Q16, 5 * Q16, 5 * Q16, Q16, 3, 3, 32'h8000_0010, 0, 0));
    send_particle(particle(10 * Q16 - 100, 5 * Q16, 5 * Q16, -7777, 1, 1, 0, 0, 0));
    send_particle(particle(5 * Q16, 10 * Q16 - 3, 5 * Q16, 9, 999, -1, 0, 0, 0));
    send_particle(particle(5 * Q16, 10 * Q16, 5 * Q16, 1, -2, 3, 4, 5, 6));
  endtask

  // Registers at the ends of their ranges.
  task automatic test_register_extremes();
    swbf_pkg::cfg_t c;
    c.wall_x_low  = 32'h8000_0000;
    c.wall_x_high = 32'h7FFF_FFFF;
    c.wall_y_low  = 32'h8000_0000;
    c.wall_y_high = 32'h7FFF_FFFF;
    c.wall_z_low  = 32'h8000_0000;
    c.contact_range  = '1;
    c.wall_stiffness = '1;
    c.wall_damping   = '1;
    program_regs(c);
    run_particles(50);
    // Inverted box with everything else at zero.
    c.wall_x_low  = 32'h7FFF_FFFF;
    c.wall_x_high = 32'h8000_0000;
    c.wall_y_low  = 32'h7FFF_FFFF;
    c.wall_y_high = 32'h8000_0000;
    c.wall_z_low  = 32'h7FFF_FFFF;
    c.contact_range  = '0;
    c.wall_stiffness = '0;
    c.wall_damping   = '0;
    program_regs(c);
    run_particles(50);
    // Degenerate box at the origin where every wall touches.
    c = '0;
    c.contact_range  = '1;
    c.wall_stiffness = '1;
    c.wall_damping   = '1;
    program_regs(c);
    run_particles(50);
  endtask

  // Random boxes; one phase runs without random gaps between words.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      gaps_on = (phase != 2);
      program_regs(rand_regs());
      run_particles(300);
    end
    gaps_on = 1'b1;
  endtask

  task automatic finish_run();
    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d particle words under %0d register settings; %0d results checked,",
             n_sent, n_settings, n_checked);
    $display("%0d of them touching a wall and %0d clamped.", n_contact, n_clamped);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = swbf_pkg::REG_WALL_X_LOW;
    cfg_data_i  = '0;
    gaps_on     = 1'b1;
    regs        = '0;
    regs.wall_x_low  = swbf_pkg::WALL_LOW_RESET;
    regs.wall_x_high = swbf_pkg::WALL_HIGH_RESET;
    regs.wall_y_low  = swbf_pkg::WALL_LOW_RESET;
    regs.wall_y_high = swbf_pkg::WALL_HIGH_RESET;
    regs.wall_z_low  = swbf_pkg::WALL_LOW_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_register_extremes();
    test_random_settings();
    finish_run();
  end

endmodule

// File: sim.f
sv/swbf_pkg.sv
sv/swbf_cfg_regs.sv
sv/swbf_contact.sv
sv/swbf_coeff.sv
sv/swbf_accum.sv
sv/sph_wall_boundary_force.sv
sv/swbf_checker.sv
sim/tb_top.sv
